// File: hdl/assert_macros.svh
// assertion macros shared by the evaluator rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never hold outside reset
`define PFE_ASSERT_NEVER(lbl, cond, msg) \
  `PFE_ASSERT(lbl, !(cond), msg)

`endif

// File: hdl/pfe_pkg.sv
// types, character codes and status codes of the postfix evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [2:0] STS_OK     = 3'd0;
  localparam logic [2:0] STS_LETTER = 3'd1;
  localparam logic [2:0] STS_UNDER  = 3'd2;
  localparam logic [2:0] STS_DIVZ   = 3'd3;
  localparam logic [2:0] STS_OVER   = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_EXEC,
    S_FIN
  } state_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    is_oper = (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

endpackage

`default_nettype wire

// File: hdl/pfe_stack.sv
// value stack storage below the top entry, one write and one read port
// uses pfe_pkg for the data width
`timescale 1ns / 1ps
`default_nettype none

module pfe_stack #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire                        clk_i,
  input  wire                        we_i,
  input  wire  [AW-1:0]              waddr_i,
  input  wire  [pfe_pkg::DATA_W-1:0] wdata_i,
  input  wire  [AW-1:0]              raddr_i,
  output logic [pfe_pkg::DATA_W-1:0] rdata_o
);
  import pfe_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/pfe_alu.sv
// serial arithmetic unit: bit-serial add and subtract, shift-add multiply,
// restoring divide; 32 steps per operation; uses pfe_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfe_alu (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  pfe_pkg::alu_req_t          req_i,
  input  wire  [pfe_pkg::DATA_W-1:0] a_i,
  input  wire  [pfe_pkg::DATA_W-1:0] b_i,
  output logic                       done_o,
  output logic [pfe_pkg::DATA_W-1:0] result_o
);
  import pfe_pkg::*;

  localparam int unsigned SW = $clog2(DATA_W);

  logic              busy_q, done_q;
  logic [SW-1:0]     step_q;
  alu_op_e           op_q;
  logic [DATA_W-1:0] x_q, x_d, y_q, y_d;
  logic [DATA_W:0]   acc_q, acc_d;
  logic              carry_q, carry_d;
  logic              neg_q;

  logic              sum_bit;
  logic [DATA_W:0]   rem_sh;
  logic              rem_ge;
  logic [DATA_W-1:0] a_abs, b_abs;

  assign a_abs = a_i[DATA_W-1] ? (~a_i + 1'b1) : a_i;
  assign b_abs = b_i[DATA_W-1] ? (~b_i + 1'b1) : b_i;

  always_comb begin
    sum_bit = x_q[0] ^ y_q[0] ^ carry_q;
    rem_sh  = {acc_q[DATA_W-1:0], x_q[DATA_W-1]};
    rem_ge  = rem_sh >= {1'b0, y_q};
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    carry_d = carry_q;
    case (op_q)
      OP_ADD, OP_SUB: begin
        // one bit per step, sum shifts in at the top
        acc_d   = {1'b0, sum_bit, acc_q[DATA_W-1:1]};
        carry_d = (x_q[0] & y_q[0]) | (carry_q & (x_q[0] ^ y_q[0]));
        x_d     = {1'b0, x_q[DATA_W-1:1]};
        y_d     = {1'b0, y_q[DATA_W-1:1]};
      end
      OP_MUL: begin
        acc_d = {1'b0, acc_q[DATA_W-1:0] + (y_q[0] ? x_q : '0)};
        x_d   = {x_q[DATA_W-2:0], 1'b0};
        y_d   = {1'b0, y_q[DATA_W-1:1]};
      end
      OP_DIV: begin
        // dividend shifts out at the top, quotient bits shift in below
        acc_d = rem_ge ? (rem_sh - {1'b0, y_q}) : rem_sh;
        x_d   = {x_q[DATA_W-2:0], rem_ge};
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q    <= req_i.op;
      acc_q   <= '0;
      neg_q   <= a_i[DATA_W-1] ^ b_i[DATA_W-1];
      carry_q <= (req_i.op == OP_SUB);
      case (req_i.op)
        OP_SUB: begin
          x_q <= a_i;
          y_q <= ~b_i;
        end
        OP_DIV: begin
          x_q <= a_abs;
          y_q <= b_abs;
        end
        default: begin
          x_q <= a_i;
          y_q <= b_i;
        end
      endcase
    end else if (busy_q) begin
      x_q     <= x_d;
      y_q     <= y_d;
      acc_q   <= acc_d;
      carry_q <= carry_d;
    end
  end

  always_comb begin
    case (op_q)
      OP_DIV:  result_o = neg_q ? (~x_q + 1'b1) : x_q;
      default: result_o = acc_q[DATA_W-1:0];
    endcase
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// File: hdl/postfix_expression_evaluator_unit.sv
// postfix evaluator top: one character per item, value stack, serial alu
// items step through the states: a digit, letter, other character or rejected operator goes
// decode, finish, idle; a divide by zero decode, read, finish; an executed operator decode, read,
// execute until the serial alu is done, then finish; a last item's result is registered in finish
// reset (async, active low) empties the stack, clears the error and the output valid flag
// the stack memory needs no clearing pass; only entries below the count are read
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module postfix_expression_evaluator_unit #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [7:0]                        char_code_i,
  input  wire                               last_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [pfe_pkg::DATA_W-1:0] value_o,
  output logic [2:0]                        status_o
);
  import pfe_pkg::*;

  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_m1, cnt_m2;
  logic [2:0]        err_q;
  logic              out_valid_q;
  logic [7:0]        char_q;
  logic              last_q;
  logic [DATA_W-1:0] top_q;
  logic [DATA_W-1:0] value_q;
  logic [2:0]        status_q;

  logic              in_acc;
  logic              ch_letter, ch_digit, ch_oper, ch_div;
  logic              no_err, full, few, div_zero;
  logic              mem_we;
  logic [DATA_W-1:0] nos;
  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_res;

  assign ch_letter = is_letter(char_q);
  assign ch_digit  = is_digit(char_q);
  assign ch_oper   = is_oper(char_q);
  assign ch_div    = (char_q == CH_SLASH);
  assign no_err    = (err_q == STS_OK);
  assign full      = (cnt_q >= CntW'(STACK_DEPTH));
  assign few       = (cnt_q < CntW'(2));
  assign div_zero  = ch_div && (top_q == '0);
  assign cnt_m1    = cnt_q - CntW'(1);
  assign cnt_m2    = cnt_q - CntW'(2);
  assign in_acc    = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DEC;
      end
      S_DEC: begin
        if (no_err && ch_oper && !few) state_d = S_RD;
        else                           state_d = S_FIN;
      end
      S_RD: begin
        if (div_zero) state_d = S_FIN;
        else          state_d = S_EXEC;
      end
      S_EXEC: begin
        if (alu_done) state_d = S_FIN;
      end
      S_FIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready_o    = 1'b0;
    mem_we        = 1'b0;
    alu_req.start = 1'b0;
    case (char_q)
      CH_PLUS:  alu_req.op = OP_ADD;
      CH_MINUS: alu_req.op = OP_SUB;
      CH_STAR:  alu_req.op = OP_MUL;
      default:  alu_req.op = OP_DIV;
    endcase
    case (state_q)
      S_IDLE: begin
        // a last item waits until the output slot is free
        in_ready_o = !out_valid_q || !last_i;
      end
      S_DEC: begin
        // push spills the old top into memory
        mem_we = no_err && ch_digit && !full && (cnt_q != '0);
      end
      S_RD: begin
        alu_req.start = !div_zero;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      err_q       <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_FIN && last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_DEC: begin
          if (no_err) begin
            if (ch_letter) begin
              err_q <= STS_LETTER;
            end else if (ch_digit) begin
              if (full) err_q <= STS_OVER;
              else      cnt_q <= cnt_q + CntW'(1);
            end else if (ch_oper && few) begin
              err_q <= STS_UNDER;
            end
          end
        end
        S_RD: begin
          if (div_zero) err_q <= STS_DIVZ;
        end
        S_EXEC: begin
          if (alu_done) cnt_q <= cnt_m1;
        end
        S_FIN: begin
          if (last_q) begin
            cnt_q <= '0;
            err_q <= STS_OK;
          end
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= char_code_i;
      last_q <= last_i;
    end
    if (state_q == S_DEC && no_err && ch_digit && !full) begin
      top_q <= {{(DATA_W - 4){1'b0}}, char_q[3:0]};
    end
    if (state_q == S_EXEC && alu_done) begin
      top_q <= alu_res;
    end
    if (state_q == S_FIN && last_q) begin
      if (!no_err) begin
        status_q <= err_q;
        value_q  <= '0;
      end else if (cnt_q == '0) begin
        status_q <= STS_UNDER;
        value_q  <= '0;
      end else begin
        status_q <= STS_OK;
        value_q  <= top_q;
      end
    end
  end

  pfe_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_m1[AW-1:0]),
    .wdata_i (top_q),
    .raddr_i (cnt_m2[AW-1:0]),
    .rdata_o (nos)
  );

  pfe_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (nos),
    .b_i      (top_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(value_q);
  assign status_o    = status_q;

  `PFE_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(STACK_DEPTH), "stack count beyond depth")
  `PFE_ASSERT(a_err_zero, out_valid_o && status_o != STS_OK |-> value_o == '0, "error value")
  `PFE_ASSERT(a_out_src, $rose(out_valid_o) |-> $past(state_q == S_FIN && last_q), "stray result")
  `PFE_ASSERT(a_err_hold, (state_q == S_DEC) && !no_err |=> $stable(cnt_q), "count moved")

endmodule

`default_nettype wire
